// ----- hw/rtl/tun_pkg.sv -----
`timescale 1ns / 1ps
package tun_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int NORMAL_WIDTH = 16;
  // cross magnitudes are cut down to this many bits before normalizing
  localparam int REDUCED_BITS = 30;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
    logic signed [COORD_WIDTH-1:0] third_x;
    logic signed [COORD_WIDTH-1:0] third_y;
    logic signed [COORD_WIDTH-1:0] third_z;
  } face_t;

  typedef struct packed {
    logic signed [NORMAL_WIDTH-1:0] normal_x;
    logic signed [NORMAL_WIDTH-1:0] normal_y;
    logic signed [NORMAL_WIDTH-1:0] normal_z;
    logic                           degenerate;
  } normal_t;

endpackage

// ----- hw/rtl/tun_root_lane.sv -----
`timescale 1ns / 1ps
// One lane of the scaled root search: finds the largest r with r*r*sum_sq <= target,
// one bit of r per stage, msb first. P = r^2*S and M = r*S are kept incrementally.
module tun_root_lane #(
  parameter int NW  = 16,
  parameter int SSW = 62,
  parameter int BW  = 92
) (
  input  logic           clk,
  input  logic           run,
  input  logic [SSW-1:0] sum_sq,
  input  logic [BW-1:0]  target,
  output logic [NW-1:0]  root
);

  localparam int PW = 2*NW + SSW;
  localparam int TW = NW + SSW;

  logic [NW-1:0]  t_q [NW];
  logic [PW-1:0]  p_q [NW];
  logic [TW-1:0]  m_q [NW];
  logic [SSW-1:0] s_q [NW];
  logic [BW-1:0]  b_q [NW];

  for (genvar g = 0; g < NW; g++) begin : g_step
    localparam int J = NW - 1 - g;
    logic [NW-1:0]  t_in;
    logic [PW-1:0]  p_in;
    logic [TW-1:0]  m_in;
    logic [SSW-1:0] s_in;
    logic [BW-1:0]  b_in;
    logic [PW-1:0]  cand;
    logic           fits;

    if (g == 0) begin : g_first
      assign t_in = '0;
      assign p_in = '0;
      assign m_in = '0;
      assign s_in = sum_sq;
      assign b_in = target;
    end else begin : g_next
      assign t_in = t_q[g-1];
      assign p_in = p_q[g-1];
      assign m_in = m_q[g-1];
      assign s_in = s_q[g-1];
      assign b_in = b_q[g-1];
    end

    // (t + 2^J)^2 S = t^2 S + 2^(J+1) t S + 2^(2J) S
    assign cand = p_in + (PW'(m_in) << (J + 1)) + (PW'(s_in) << (2 * J));
    assign fits = (cand <= PW'(b_in));

    always_ff @(posedge clk) begin
      if (run) begin
        t_q[g] <= fits ? (t_in | (NW'(1) << J)) : t_in;
        p_q[g] <= fits ? cand : p_in;
        m_q[g] <= fits ? (m_in + (TW'(s_in) << J)) : m_in;
        s_q[g] <= s_in;
        b_q[g] <= b_in;
      end
    end
  end

  assign root = t_q[NW-1];

endmodule

// ----- hw/rtl/triangle_unit_normal_core.sv -----
`timescale 1ns / 1ps
// Triangle face normal unit.
// face channel: one triangle per transfer (three vertices, signed Q8.16).
// normal channel: one result per triangle, in order: the negated unit normal in
// signed Q1.15 scaled by 32767, rounded to nearest, plus a degenerate flag that is
// set (with a zero normal) when the cross product of the edges is exactly zero.
// Throughput: one triangle per cycle while the normal side takes results.
// Pipeline: eight front stages (edges, products, cross, length, reduce, square,
// sum and partial products, target), one stage per result bit of the root search,
// and the output register.
// The pipeline moves as a whole. When normal_stall holds a result, one more result
// drops into a skid register and the pipeline keeps taking faces; face_stall rises
// only once the skid register is full, and falls again the cycle after it drains.
// Reset (rst, synchronous) clears all valid bits; nothing is in flight after it.
module triangle_unit_normal_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             face_valid,
  output logic             face_stall,
  input  tun_pkg::face_t   face,
  output logic             normal_valid,
  input  logic             normal_stall,
  output tun_pkg::normal_t normal
);
  import tun_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int NW    = NORMAL_WIDTH;
  localparam int RB    = REDUCED_BITS;
  localparam int EW    = CW + 1;          // edge
  localparam int PRW   = 2 * EW;          // edge product
  localparam int CXW   = PRW + 1;         // cross component
  localparam int LW    = $clog2(CXW + 1); // bit length
  localparam int SW    = (CXW > RB) ? CXW : RB;
  localparam int SSW   = 2 * RB + 2;      // sum of squares
  localparam int MW    = 2 * NW;
  localparam int BW    = 2 * NW + 2 * RB; // (2K a)^2
  localparam int PPW   = RB + NW;
  localparam int FRONT = 8;
  localparam int DEPTH = FRONT + NW;

  // (2K)^2 with K = 2^(NW-1) - 1
  localparam logic [MW-1:0] SCALE_SQ =
    MW'(((64'd1 << NW) - 64'd2) * ((64'd1 << NW) - 64'd2));

  logic             run;
  logic [DEPTH-1:0] vld;
  logic             skid_valid;
  normal_t          skid;
  normal_t          fin;

  // stage registers
  logic signed [EW-1:0]  e0 [3];
  logic signed [EW-1:0]  e1 [3];
  logic signed [PRW-1:0] prod [6];
  logic [CXW-1:0]        mag3 [3];
  logic [2:0]            neg3;
  logic [CXW-1:0]        mag4 [3];
  logic [2:0]            neg4;
  logic [LW-1:0]         len4;
  logic [RB-1:0]         a5 [3];
  logic [2:0]            neg5;
  logic                  deg5;
  logic [2*RB-1:0]       sq6 [3];
  logic [2:0]            neg6;
  logic                  deg6;
  logic [SSW-1:0]        ssum7;
  logic [PPW-1:0]        pp7 [3][4];
  logic [2:0]            neg7;
  logic                  deg7;
  logic [SSW-1:0]        ssum8;
  logic [BW-1:0]         tgt8 [3];
  logic [2:0]            neg8;
  logic                  deg8;
  logic [3:0]            meta [NW];
  logic [NW-1:0]         root [3];

  // combinational helpers
  logic signed [CXW-1:0] xprod [3];
  logic [CXW-1:0]        merged;
  logic [LW-1:0]         len;
  logic [SW-1:0]         ext [3];
  logic [RB-1:0]         red [3];
  logic [NW:0]           rnd [3];
  logic [NW-1:0]         q [3];
  logic [NW-1:0]         res [3];

  assign run        = !skid_valid;
  assign face_stall = !run;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (run) begin
      vld <= {vld[DEPTH-2:0], face_valid};
    end
  end

  // cross components, sign and magnitude
  always_comb begin
    xprod[0] = CXW'(prod[0]) - CXW'(prod[1]);
    xprod[1] = CXW'(prod[2]) - CXW'(prod[3]);
    xprod[2] = CXW'(prod[4]) - CXW'(prod[5]);
  end

  // bit length of the largest magnitude = bit length of the OR
  always_comb begin
    merged = mag3[0] | mag3[1] | mag3[2];
    len    = '0;
    for (int i = 0; i < CXW; i++) begin
      if (merged[i]) len = LW'(i + 1);
    end
  end

  // keep the top RB bits, truncating
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = SW'(mag4[i]);
      if (int'(len4) > RB) ext[i] = ext[i] >> (len4 - LW'(RB));
      red[i] = ext[i][RB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      // edges: E0 = third - first, E1 = second - first
      e0[0] <= EW'(face.third_x) - EW'(face.first_x);
      e0[1] <= EW'(face.third_y) - EW'(face.first_y);
      e0[2] <= EW'(face.third_z) - EW'(face.first_z);
      e1[0] <= EW'(face.second_x) - EW'(face.first_x);
      e1[1] <= EW'(face.second_y) - EW'(face.first_y);
      e1[2] <= EW'(face.second_z) - EW'(face.first_z);

      prod[0] <= e0[1] * e1[2];
      prod[1] <= e0[2] * e1[1];
      prod[2] <= e0[2] * e1[0];
      prod[3] <= e0[0] * e1[2];
      prod[4] <= e0[0] * e1[1];
      prod[5] <= e0[1] * e1[0];

      for (int i = 0; i < 3; i++) begin
        neg3[i] <= xprod[i][CXW-1];
        mag3[i] <= xprod[i][CXW-1] ? CXW'(-xprod[i]) : CXW'(xprod[i]);
      end

      mag4 <= mag3;
      neg4 <= neg3;
      len4 <= len;

      a5   <= red;
      neg5 <= neg4;
      deg5 <= (len4 == '0);

      for (int i = 0; i < 3; i++) begin
        sq6[i] <= a5[i] * a5[i];
      end
      neg6 <= neg5;
      deg6 <= deg5;

      ssum7 <= SSW'(sq6[0]) + SSW'(sq6[1]) + SSW'(sq6[2]);
      for (int i = 0; i < 3; i++) begin
        pp7[i][0] <= sq6[i][RB-1:0]      * SCALE_SQ[NW-1:0];
        pp7[i][1] <= sq6[i][RB-1:0]      * SCALE_SQ[MW-1:NW];
        pp7[i][2] <= sq6[i][2*RB-1:RB]   * SCALE_SQ[NW-1:0];
        pp7[i][3] <= sq6[i][2*RB-1:RB]   * SCALE_SQ[MW-1:NW];
      end
      neg7 <= neg6;
      deg7 <= deg6;

      ssum8 <= ssum7;
      for (int i = 0; i < 3; i++) begin
        tgt8[i] <= BW'(pp7[i][0]) + (BW'(pp7[i][1]) << NW)
                 + (BW'(pp7[i][2]) << RB) + (BW'(pp7[i][3]) << (RB + NW));
      end
      neg8 <= neg7;
      deg8 <= deg7;

      // flags ride alongside the root search
      meta[0] <= {deg8, neg8};
      for (int g = 1; g < NW; g++) begin
        meta[g] <= meta[g-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    tun_root_lane #(
      .NW  (NW),
      .SSW (SSW),
      .BW  (BW)
    ) u_lane (
      .clk    (clk),
      .run    (run),
      .sum_sq (ssum8),
      .target (tgt8[i]),
      .root   (root[i])
    );
  end

  // largest odd t <= root gives the rounded magnitude (root + 1) / 2
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = (NW + 1)'(root[i]) + (NW + 1)'(1);
      q[i]   = rnd[i][NW:1];
      if (meta[NW-1][3])      res[i] = '0;
      else if (meta[NW-1][i]) res[i] = q[i];
      else                    res[i] = NW'(-q[i]);
    end
    fin.normal_x   = res[0];
    fin.normal_y   = res[1];
    fin.normal_z   = res[2];
    fin.degenerate = meta[NW-1][3];
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!normal_valid || !normal_stall) begin
      if (skid_valid) begin
        normal_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        normal_valid <= vld[DEPTH-1];
      end
    end else if (run && vld[DEPTH-1]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!normal_valid || !normal_stall) begin
      normal <= skid_valid ? skid : fin;
    end else if (run) begin
      skid <= fin;
    end
  end

endmodule

// ----- hw/rtl/tun_checker.sv -----
`timescale 1ns / 1ps
module tun_checker (
  input logic             clk,
  input logic             rst,
  input logic             face_valid,
  input logic             face_stall,
  input tun_pkg::face_t   face,
  input logic             normal_valid,
  input logic             normal_stall,
  input tun_pkg::normal_t normal
);
  import tun_pkg::*;

  localparam logic [NORMAL_WIDTH-1:0] MOST_NEG = {1'b1, {(NORMAL_WIDTH-1){1'b0}}};

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !normal_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    normal_valid && normal_stall |=> normal_valid && $stable(normal))
    else $error("stalled result changed");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    normal_valid && normal.degenerate |->
      normal.normal_x == '0 && normal.normal_y == '0 && normal.normal_z == '0)
    else $error("degenerate result with nonzero normal");

  a_range: assert property (@(posedge clk) disable iff (rst)
    normal_valid |-> normal.normal_x != MOST_NEG && normal.normal_y != MOST_NEG
      && normal.normal_z != MOST_NEG)
    else $error("normal component out of range");

endmodule

bind triangle_unit_normal_core tun_checker u_tun_checker (.*);
